### rtl/core/semaphore_table_with_wait_queues_defines.svh
// assertion macros for the semaphore table
// used by semaphore_table_with_wait_queues.sv, expects clk and rst_n in scope
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_DEFINES_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_DEFINES_SVH

// same-cycle implication
`define SEM_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("semaphore table check failed");

// next-cycle implication
`define SEM_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("semaphore table check failed");

`endif

### rtl/core/semtab_pkg.sv
// types, sizes and text helper for the semaphore table
// no dependencies
`default_nettype none
package semtab_pkg;
  localparam int MAX_SEM   = 16;
  localparam int MAX_WAIT  = 8;
  localparam int REQ_BITS  = 8;
  localparam int TEXT_BITS = 256;
  localparam int ID_W      = 31;
  localparam int VAL_W     = 32;
  localparam int SEM_W     = (MAX_SEM > 1) ? $clog2(MAX_SEM) : 1;
  localparam int HEAD_W    = (MAX_WAIT > 1) ? $clog2(MAX_WAIT) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAIT + 1);
  localparam int LIVE_W    = $clog2(MAX_SEM + 1);
  localparam int WADDR_W   = (MAX_SEM * MAX_WAIT > 1) ? $clog2(MAX_SEM * MAX_WAIT) : 1;
  localparam logic signed [VAL_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_OPEN   = 3'd1,
    KIND_DOWN   = 3'd2,
    KIND_UP     = 3'd3,
    KIND_CLOSE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WQ_RD,
    ST_FINISH
  } state_t;

  // zero every byte from the first nul byte on
  function automatic logic [TEXT_BITS-1:0] text_norm(input logic [TEXT_BITS-1:0] src);
    logic [TEXT_BITS/8-1:0] zf;
    logic [TEXT_BITS-1:0]   res;
    for (int j = 0; j < TEXT_BITS / 8; j++) begin
      zf[j] = (src[8*j +: 8] == 8'd0);
    end
    for (int b = 0; b < TEXT_BITS / 8; b++) begin
      res[8*b +: 8] = ((zf & ((TEXT_BITS/8)'(2) << b) - (TEXT_BITS/8)'(1)) != '0) ?
                      8'd0 : src[8*b +: 8];
    end
    return res;
  endfunction
endpackage
`default_nettype wire

### rtl/core/semaphore_table_with_wait_queues.sv
// semaphore table with per-entry wait queues, top level
// depends on semtab_pkg and semaphore_table_with_wait_queues_defines.svh
// each item walks every entry (read, then compare) through the single read port of the
//   name/key store, with an extra waiter read for up
// throughput: one item at a time, next item taken once the block is back in idle
// reset: synchronous active low, clears valid bits, queue heads/counts, id counter;
//   no clearing pass, stored names, keys and waiters are undefined until written
`default_nettype none
`include "semaphore_table_with_wait_queues_defines.svh"
module semaphore_table_with_wait_queues (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               in_kind,
  input  wire logic signed [31:0]       in_init_value,
  input  wire logic [63:0]              in_name_word0,
  input  wire logic [63:0]              in_name_word1,
  input  wire logic [63:0]              in_name_word2,
  input  wire logic [63:0]              in_name_word3,
  input  wire logic [63:0]              in_key_word0,
  input  wire logic [63:0]              in_key_word1,
  input  wire logic [63:0]              in_key_word2,
  input  wire logic [63:0]              in_key_word3,
  input  wire logic [30:0]              in_target_id,
  input  wire logic [7:0]               in_requester,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_failed,
  output logic [30:0]                   out_result_id,
  output logic                          out_must_sleep,
  output logic                          out_woke_valid,
  output logic [7:0]                    out_woke_requester
);
  localparam int SEM_W   = semtab_pkg::SEM_W;
  localparam int HEAD_W  = semtab_pkg::HEAD_W;
  localparam int WCNT_W  = semtab_pkg::WCNT_W;
  localparam int WADDR_W = semtab_pkg::WADDR_W;
  localparam int TB      = semtab_pkg::TEXT_BITS;
  localparam int ID_W    = semtab_pkg::ID_W;
  localparam int VAL_W   = semtab_pkg::VAL_W;
  localparam int RB      = semtab_pkg::REQ_BITS;
  localparam int NS      = semtab_pkg::MAX_SEM;
  localparam logic [SEM_W-1:0]   LAST_IDX = SEM_W'(NS - 1);
  localparam logic [WADDR_W-1:0] WQ_STRIDE = WADDR_W'(semtab_pkg::MAX_WAIT);
  localparam logic [WCNT_W:0]    WAIT_SUM  = (WCNT_W+1)'(semtab_pkg::MAX_WAIT);
  localparam logic [WCNT_W-1:0]  WAIT_FULL = WCNT_W'(semtab_pkg::MAX_WAIT);
  localparam logic [HEAD_W-1:0]  HEAD_LAST = HEAD_W'(semtab_pkg::MAX_WAIT - 1);

  // sequencer
  semtab_pkg::state_t state_r, state_nxt;

  // captured item
  logic [2:0]              kind_r;
  logic signed [VAL_W-1:0] value_r;
  logic [TB-1:0]           name_r, key_r;
  logic [ID_W-1:0]         id_r;
  logic [RB-1:0]           who_r;

  // walk state
  logic [SEM_W-1:0] idx_r;
  logic             best_v_r, best_key_ok_r, free_v_r;
  logic [SEM_W-1:0] best_r, best_rank_r, free_r;

  // table in flops
  logic [NS-1:0]                  live_r;
  logic [ID_W-1:0]                ident_r [NS];
  logic signed [VAL_W-1:0]        count_r [NS];
  logic [SEM_W-1:0]               rank_r  [NS];
  logic [HEAD_W-1:0]              whead_r [NS];
  logic [WCNT_W-1:0]              wcnt_r  [NS];
  logic [ID_W-1:0]                next_id_r;
  logic [semtab_pkg::LIVE_W-1:0]  live_total_r;

  // memories for text and waiters
  logic [TB-1:0] name_mem [NS];
  logic [TB-1:0] key_mem  [NS];
  logic [RB-1:0] wq_mem   [NS * semtab_pkg::MAX_WAIT];
  logic [TB-1:0] name_q, key_q;
  logic [RB-1:0] wq_q;

  // output register
  logic            out_valid_r, failed_r, sleep_r, woke_r;
  logic [ID_W-1:0] rid_r;
  logic [7:0]      woke_who_r;

  logic accept, commit;
  assign in_ready = (state_r == semtab_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == semtab_pkg::ST_FINISH) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= semtab_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      semtab_pkg::ST_IDLE:     if (in_valid) state_nxt = semtab_pkg::ST_SCAN_RD;
      semtab_pkg::ST_SCAN_RD:  state_nxt = semtab_pkg::ST_SCAN_CMP;
      semtab_pkg::ST_SCAN_CMP: begin
        if (idx_r != LAST_IDX)                   state_nxt = semtab_pkg::ST_SCAN_RD;
        else if (kind_r == semtab_pkg::KIND_UP)  state_nxt = semtab_pkg::ST_WQ_RD;
        else                                     state_nxt = semtab_pkg::ST_FINISH;
      end
      semtab_pkg::ST_WQ_RD:    state_nxt = semtab_pkg::ST_FINISH;
      semtab_pkg::ST_FINISH:   if (commit) state_nxt = semtab_pkg::ST_IDLE;
      default:                 state_nxt = semtab_pkg::ST_IDLE;
    endcase
  end

  // text is stored and compared in normalized form
  logic [TB-1:0] in_name_n, in_key_n;
  assign in_name_n = semtab_pkg::text_norm({in_name_word3, in_name_word2,
                                            in_name_word1, in_name_word0});
  assign in_key_n  = semtab_pkg::text_norm({in_key_word3, in_key_word2,
                                            in_key_word1, in_key_word0});

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      value_r <= in_init_value;
      name_r  <= in_name_n;
      key_r   <= in_key_n;
      id_r    <= in_target_id;
      who_r   <= in_requester[RB-1:0];
    end
  end

  // each entry is read, then compared
  logic scan_match, scan_better;
  always_comb begin
    if (kind_r == semtab_pkg::KIND_OPEN) scan_match = live_r[idx_r] && (name_q == name_r);
    else                                 scan_match = live_r[idx_r] && (ident_r[idx_r] == id_r);
    scan_better = scan_match && (!best_v_r || (rank_r[idx_r] < best_rank_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
      idx_r    <= '0;
    end else if (accept) begin
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
      idx_r    <= '0;
    end else if (state_r == semtab_pkg::ST_SCAN_CMP) begin
      if (scan_better) begin
        best_v_r      <= 1'b1;
        best_r        <= idx_r;
        best_rank_r   <= rank_r[idx_r];
        best_key_ok_r <= (key_q == key_r);
      end
      // lowest free slot for create
      if (!live_r[idx_r] && !free_v_r) begin
        free_v_r <= 1'b1;
        free_r   <= idx_r;
      end
      if (idx_r != LAST_IDX) idx_r <= idx_r + SEM_W'(1);
    end
  end

  // selected entry
  logic signed [VAL_W-1:0] cur_cnt, dec_cnt, inc_cnt;
  logic [WCNT_W-1:0]       cur_wc;
  logic [HEAD_W-1:0]       cur_wh, tail, head_inc;
  logic [WCNT_W:0]         tsum;
  logic [WADDR_W-1:0]      wq_wr_addr, wq_rd_addr;
  assign cur_cnt  = count_r[best_r];
  assign cur_wc   = wcnt_r[best_r];
  assign cur_wh   = whead_r[best_r];
  assign dec_cnt  = cur_cnt - 32'sd1;
  assign inc_cnt  = cur_cnt + 32'sd1;
  assign tsum     = (WCNT_W+1)'(cur_wh) + (WCNT_W+1)'(cur_wc);
  assign tail     = (tsum >= WAIT_SUM) ? HEAD_W'(tsum - WAIT_SUM) : HEAD_W'(tsum);
  assign head_inc = (cur_wh == HEAD_LAST) ? '0 : cur_wh + HEAD_W'(1);
  assign wq_wr_addr = WADDR_W'(best_r) * WQ_STRIDE + WADDR_W'(tail);
  assign wq_rd_addr = WADDR_W'(best_r) * WQ_STRIDE + WADDR_W'(cur_wh);

  // result and table effect of the finished walk
  logic            r_failed, r_sleep, r_woke;
  logic [ID_W-1:0] r_rid;
  logic            do_create, do_down, do_up_inc, do_wake, do_close;
  always_comb begin
    r_failed  = 1'b1;
    r_sleep   = 1'b0;
    r_woke    = 1'b0;
    r_rid     = '0;
    do_create = 1'b0;
    do_down   = 1'b0;
    do_up_inc = 1'b0;
    do_wake   = 1'b0;
    do_close  = 1'b0;
    unique case (kind_r)
      semtab_pkg::KIND_CREATE: begin
        if (!value_r[VAL_W-1] && name_r[7:0] != 8'd0 && key_r[7:0] != 8'd0 && free_v_r) begin
          do_create = 1'b1;
          r_failed  = 1'b0;
          r_rid     = next_id_r;
        end
      end
      semtab_pkg::KIND_OPEN: begin
        if (best_v_r && best_key_ok_r) begin
          r_failed = 1'b0;
          r_rid    = ident_r[best_r];
        end
      end
      semtab_pkg::KIND_DOWN: begin
        if (best_v_r) begin
          // sleeping down with a full queue is refused
          if (!dec_cnt[VAL_W-1] || cur_wc < WAIT_FULL) begin
            do_down  = 1'b1;
            r_failed = 1'b0;
            r_sleep  = dec_cnt[VAL_W-1];
          end
        end
      end
      semtab_pkg::KIND_UP: begin
        if (best_v_r) begin
          r_failed = 1'b0;
          // saturated value: no change, no wake
          if (cur_cnt != semtab_pkg::VALUE_MAX) begin
            do_up_inc = 1'b1;
            if ((inc_cnt[VAL_W-1] || inc_cnt == '0) && cur_wc != '0) begin
              do_wake = 1'b1;
              r_woke  = 1'b1;
            end
          end
        end
      end
      semtab_pkg::KIND_CLOSE: begin
        if (best_v_r && cur_wc == '0) begin
          do_close = 1'b1;
          r_failed = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      next_id_r    <= ID_W'(1);
      live_total_r <= '0;
      for (int i = 0; i < NS; i++) begin
        whead_r[i] <= '0;
        wcnt_r[i]  <= '0;
      end
    end else if (commit) begin
      if (do_create) begin
        live_r[free_r]  <= 1'b1;
        ident_r[free_r] <= next_id_r;
        count_r[free_r] <= value_r;
        rank_r[free_r]  <= SEM_W'(live_total_r);
        whead_r[free_r] <= '0;
        wcnt_r[free_r]  <= '0;
        live_total_r    <= live_total_r + 1'b1;
        next_id_r       <= next_id_r + ID_W'(1);
      end
      if (do_down) begin
        count_r[best_r] <= dec_cnt;
        if (r_sleep) wcnt_r[best_r] <= cur_wc + WCNT_W'(1);
      end
      if (do_up_inc) count_r[best_r] <= inc_cnt;
      if (do_wake) begin
        whead_r[best_r] <= head_inc;
        wcnt_r[best_r]  <= cur_wc - WCNT_W'(1);
      end
      if (do_close) begin
        live_r[best_r] <= 1'b0;
        live_total_r   <= live_total_r - 1'b1;
        // younger entries move up one rank
        for (int i = 0; i < NS; i++) begin
          if (live_r[i] && rank_r[i] > rank_r[best_r]) rank_r[i] <= rank_r[i] - SEM_W'(1);
        end
      end
    end
  end

  // text store, one row per entry
  always_ff @(posedge clk) begin
    if (commit && do_create) begin
      name_mem[free_r] <= name_r;
      key_mem[free_r]  <= key_r;
    end
    name_q <= name_mem[idx_r];
    key_q  <= key_mem[idx_r];
  end

  // waiter store
  always_ff @(posedge clk) begin
    if (commit && do_down && r_sleep) wq_mem[wq_wr_addr] <= who_r;
    wq_q <= wq_mem[wq_rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (commit) begin
      failed_r   <= r_failed;
      rid_r      <= r_rid;
      sleep_r    <= r_sleep;
      woke_r     <= r_woke;
      woke_who_r <= r_woke ? 8'(wq_q) : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_failed         = failed_r;
  assign out_result_id      = rid_r;
  assign out_must_sleep     = sleep_r;
  assign out_woke_valid     = woke_r;
  assign out_woke_requester = woke_who_r;

  // live count tracks the valid bits
  `SEM_AST_IMP(a_live_total, 1'b1, live_total_r == $countones(live_r))
  // an accepted item keeps the block busy
  `SEM_AST_NXT(a_busy, accept, !in_ready)
  // a wake is never a failure or a sleep
  `SEM_AST_IMP(a_wake_ok, out_valid_r && woke_r, !failed_r && !sleep_r)
endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench for semaphore_table_with_wait_queues
// depends on semtab_pkg and the rtl top level; a scoreboard predicts every result
`default_nettype none
module testbench;
  import semtab_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 1225;
  localparam int HOLD_CYCLES    = 300;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] init_value;
    logic [255:0]       name;
    logic [255:0]       key;
    logic [30:0]        target_id;
    logic [7:0]         requester;
  } sem_req_t;

  typedef struct {
    logic        failed;
    logic [30:0] result_id;
    logic        must_sleep;
    logic        woke_valid;
    logic [7:0]  woke_requester;
  } sem_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic signed [31:0] in_init_value = '0;
  logic [255:0] in_name = '0;
  logic [255:0] in_key = '0;
  logic [30:0] in_target_id = '0;
  logic [7:0] in_requester = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_failed;
  logic [30:0] out_result_id;
  logic out_must_sleep;
  logic out_woke_valid;
  logic [7:0] out_woke_requester;

  always #5 clk = ~clk;

  semaphore_table_with_wait_queues dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_init_value(in_init_value),
    .in_name_word0(in_name[63:0]), .in_name_word1(in_name[127:64]),
    .in_name_word2(in_name[191:128]), .in_name_word3(in_name[255:192]),
    .in_key_word0(in_key[63:0]), .in_key_word1(in_key[127:64]),
    .in_key_word2(in_key[191:128]), .in_key_word3(in_key[255:192]),
    .in_target_id(in_target_id), .in_requester(in_requester),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_failed(out_failed), .out_result_id(out_result_id),
    .out_must_sleep(out_must_sleep), .out_woke_valid(out_woke_valid),
    .out_woke_requester(out_woke_requester)
  );

  // ---------------------------------------------------------------
  // shadow semaphore table
  // ---------------------------------------------------------------
  logic               sh_live  [MAX_SEM];
  logic [30:0]        sh_ident [MAX_SEM];
  logic signed [31:0] sh_value [MAX_SEM];
  logic [255:0]       sh_name  [MAX_SEM];
  logic [255:0]       sh_key   [MAX_SEM];
  logic [7:0]         sh_wait  [MAX_SEM][MAX_WAIT];
  int                 sh_head  [MAX_SEM];
  int                 sh_depth [MAX_SEM];
  int                 sh_age   [MAX_SEM];
  int                 sh_total;
  logic [30:0]        sh_next_id;

  sem_req_t pending_reqs[$];
  sem_rsp_t expected_rsps[$];
  int       error_count = 0;

  // text ends at the first nul byte, everything after reads as zero
  function automatic logic [255:0] clip_text(input logic [255:0] src);
    logic [255:0] res;
    logic ended;
    res = '0;
    ended = 1'b0;
    for (int b = 0; b < 32; b++) begin
      if (src[8*b +: 8] == 8'd0) ended = 1'b1;
      if (!ended) res[8*b +: 8] = src[8*b +: 8];
    end
    return res;
  endfunction

  // oldest live entry carrying this id, -1 if none
  function automatic int lookup_id(input logic [30:0] id);
    int best;
    best = -1;
    for (int i = 0; i < MAX_SEM; i++)
      if (sh_live[i] && sh_ident[i] == id && (best < 0 || sh_age[i] < sh_age[best]))
        best = i;
    return best;
  endfunction

  task automatic apply_request(input sem_req_t rq, output sem_rsp_t rs);
    logic [255:0] nm;
    logic [255:0] ky;
    int e;
    nm = clip_text(rq.name);
    ky = clip_text(rq.key);
    rs = '{failed: 1'b1, result_id: '0, must_sleep: 1'b0, woke_valid: 1'b0,
           woke_requester: '0};
    e = -1;
    case (rq.kind)
      KIND_CREATE: begin
        if (rq.init_value >= 0 && nm[7:0] != 0 && ky[7:0] != 0) begin
          for (int i = MAX_SEM - 1; i >= 0; i--)
            if (!sh_live[i]) e = i;
          if (e >= 0) begin
            sh_live[e] = 1'b1;
            sh_ident[e] = sh_next_id;
            sh_value[e] = rq.init_value;
            sh_name[e] = nm;
            sh_key[e] = ky;
            sh_head[e] = 0;
            sh_depth[e] = 0;
            sh_age[e] = sh_total;
            sh_total++;
            rs.result_id = sh_next_id;
            sh_next_id = sh_next_id + 31'd1;
            rs.failed = 1'b0;
          end
        end
      end
      KIND_OPEN: begin
        for (int i = 0; i < MAX_SEM; i++)
          if (sh_live[i] && sh_name[i] == nm && (e < 0 || sh_age[i] < sh_age[e]))
            e = i;
        if (e >= 0 && sh_key[e] == ky) begin
          rs.result_id = sh_ident[e];
          rs.failed = 1'b0;
        end
      end
      KIND_DOWN: begin
        e = lookup_id(rq.target_id);
        if (e >= 0) begin
          if (sh_value[e] <= 0) begin
            // a full queue undoes the down
            if (sh_depth[e] < MAX_WAIT) begin
              sh_wait[e][(sh_head[e] + sh_depth[e]) % MAX_WAIT] = rq.requester;
              sh_depth[e]++;
              sh_value[e] = sh_value[e] - 1;
              rs.must_sleep = 1'b1;
              rs.failed = 1'b0;
            end
          end else begin
            sh_value[e] = sh_value[e] - 1;
            rs.failed = 1'b0;
          end
        end
      end
      KIND_UP: begin
        e = lookup_id(rq.target_id);
        if (e >= 0) begin
          rs.failed = 1'b0;
          // saturates at the top, nobody woken
          if (sh_value[e] != VALUE_MAX) begin
            sh_value[e] = sh_value[e] + 1;
            if (sh_value[e] <= 0 && sh_depth[e] > 0) begin
              rs.woke_valid = 1'b1;
              rs.woke_requester = sh_wait[e][sh_head[e]];
              sh_head[e] = (sh_head[e] + 1) % MAX_WAIT;
              sh_depth[e]--;
            end
          end
        end
      end
      KIND_CLOSE: begin
        e = lookup_id(rq.target_id);
        if (e >= 0 && sh_depth[e] == 0) begin
          sh_live[e] = 1'b0;
          for (int i = 0; i < MAX_SEM; i++)
            if (sh_live[i] && sh_age[i] > sh_age[e]) sh_age[i]--;
          sh_total--;
          rs.failed = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  function automatic logic [255:0] junk_text();
    logic [255:0] t;
    for (int w = 0; w < 8; w++) t[32*w +: 32] = $urandom;
    return t;
  endfunction

  // short text like "s3" or "k1", with junk past the nul half of the time
  function automatic logic [255:0] short_text(input logic [7:0] lead, input int n);
    logic [255:0] t;
    t = '0;
    if ($urandom_range(1, 0) == 1) t = junk_text();
    t[7:0] = lead;
    t[15:8] = 8'h30 + n[7:0];
    t[23:16] = 8'h00;
    return t;
  endfunction

  function automatic sem_req_t make_req(input logic [2:0] k, input int val,
                                        input logic [255:0] nm,
                                        input logic [255:0] ky, input int id,
                                        input int who);
    sem_req_t r;
    r.kind = k;
    r.init_value = val;
    r.name = nm;
    r.key = ky;
    r.target_id = id[30:0];
    r.requester = who[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------
  // sender: bursts and gaps, inputs change on the falling edge
  // ---------------------------------------------------------------
  logic in_fire, out_fire;
  logic in_fire_seen = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   accepted_items = 0;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire_seen)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        sem_req_t r;
        r = pending_reqs.pop_front();
        in_kind <= r.kind;
        in_init_value <= r.init_value;
        in_name <= r.name;
        in_key <= r.key;
        in_target_id <= r.target_id;
        in_requester <= r.requester;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          // some bursts run back to back with no gap
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted item: predict its result at the same edge
  always @(posedge clk) begin
    in_fire_seen <= in_fire;
    if (in_fire) begin
      sem_req_t r;
      sem_rsp_t s;
      r = '{kind: in_kind, init_value: in_init_value, name: in_name, key: in_key,
            target_id: in_target_id, requester: in_requester};
      apply_request(r, s);
      expected_rsps.push_back(s);
      accepted_items <= accepted_items + 1;
    end
  end

  // ---------------------------------------------------------------
  // receiver: own stall pattern plus one long hold-off
  // ---------------------------------------------------------------
  int  recv_cycle = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    recv_cycle <= recv_cycle + 1;
    if (!hold_done && accepted_items >= 400) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_cycle[9:8] == 2'd0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(3, 0) != 0) && (recv_cycle % 11 != 5);
    end
  end

  // ---------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (out_fire) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected item: failed=%0d id=%0d", $time, out_failed,
                 out_result_id);
        error_count++;
      end else begin
        sem_rsp_t x;
        x = expected_rsps.pop_front();
        if (out_failed !== x.failed) begin
          $display("%0t: failed expected %0d actual %0d", $time, x.failed, out_failed);
          error_count++;
        end
        if (out_result_id !== x.result_id) begin
          $display("%0t: result_id expected %0d actual %0d", $time, x.result_id,
                   out_result_id);
          error_count++;
        end
        if (out_must_sleep !== x.must_sleep) begin
          $display("%0t: must_sleep expected %0d actual %0d", $time, x.must_sleep,
                   out_must_sleep);
          error_count++;
        end
        if (out_woke_valid !== x.woke_valid) begin
          $display("%0t: woke_valid expected %0d actual %0d", $time, x.woke_valid,
                   out_woke_valid);
          error_count++;
        end
        if (out_woke_requester !== x.woke_requester) begin
          $display("%0t: woke_requester expected %0d actual %0d", $time,
                   x.woke_requester, out_woke_requester);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (in_fire || out_fire || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("semaphore_table_with_wait_queues regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    logic [255:0] full_name;
    int id_hi;
    int pick;
    int val;
    logic [255:0] nm;
    logic [255:0] ky;
    int tid;

    for (int i = 0; i < MAX_SEM; i++) begin
      sh_live[i] = 1'b0;
      sh_head[i] = 0;
      sh_depth[i] = 0;
      sh_age[i] = 0;
    end
    sh_total = 0;
    sh_next_id = 31'd1;

    // directed part
    full_name = junk_text() | {32{8'h01}};
    pending_reqs.push_back(make_req(KIND_CREATE, 0, short_text("s", 0), short_text("k", 0), 0, 0));
    // duplicate name, open must return the older id
    pending_reqs.push_back(make_req(KIND_CREATE, 1, short_text("s", 0), short_text("k", 1), 0, 0));
    pending_reqs.push_back(make_req(KIND_OPEN, 0, short_text("s", 0), short_text("k", 0), 0, 0));
    pending_reqs.push_back(make_req(KIND_OPEN, 0, short_text("s", 0), short_text("k", 1), 0, 0));
    pending_reqs.push_back(make_req(KIND_OPEN, 0, short_text("s", 9), short_text("k", 0), 0, 0));
    pending_reqs.push_back(make_req(KIND_CREATE, -1, short_text("s", 1), short_text("k", 0), 0, 0));
    pending_reqs.push_back(make_req(KIND_CREATE, 3, '0, short_text("k", 0), 0, 0));
    pending_reqs.push_back(make_req(KIND_CREATE, 3, short_text("s", 1), junk_text() & ~256'hFF,
                                    0, 0));
    // nine downs on a zero value: eight sleep, the last finds the queue full
    for (int i = 0; i < 9; i++)
      pending_reqs.push_back(make_req(KIND_DOWN, 0, '0, '0, 1, (i == 0) ? 255 : i * 29));
    pending_reqs.push_back(make_req(KIND_CLOSE, 0, '0, '0, 1, 0));
    pending_reqs.push_back(make_req(KIND_UP, 0, '0, '0, 1, 0));
    pending_reqs.push_back(make_req(KIND_UP, 0, '0, '0, 31'h7FFFFFFF, 0));
    pending_reqs.push_back(make_req(KIND_CLOSE, 0, '0, '0, 77, 0));
    pending_reqs.push_back(make_req(3'd7, 0, '0, '0, 0, 0));
    pending_reqs.push_back(make_req(3'd5, 0, '0, '0, 0, 0));
    pending_reqs.push_back(make_req(KIND_CREATE, 32'h7FFFFFFF, full_name, full_name, 0, 0));
    pending_reqs.push_back(make_req(KIND_UP, 0, '0, '0, 3, 0));
    pending_reqs.push_back(make_req(KIND_OPEN, 0, full_name, full_name, 0, 0));
    pending_reqs.push_back(make_req(KIND_CLOSE, 0, '0, '0, 2, 0));

    // random part, ids aimed near the ones recently handed out
    id_hi = 4;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99, 0);
      nm = ($urandom_range(9, 0) == 0) ? junk_text() : short_text("s", $urandom_range(7, 0));
      ky = ($urandom_range(9, 0) == 0) ? junk_text() : short_text("k", $urandom_range(2, 0));
      val = ($urandom_range(19, 0) == 0) ? $urandom : $urandom_range(3, 0);
      tid = ($urandom_range(19, 0) == 0) ? $urandom :
            $urandom_range(id_hi, (id_hi > 24) ? id_hi - 24 : 0);
      if (pick < 24) begin
        pending_reqs.push_back(make_req(KIND_CREATE, val, nm, ky, tid, $urandom));
        id_hi++;
      end else if (pick < 38) begin
        pending_reqs.push_back(make_req(KIND_OPEN, val, nm, ky, tid, $urandom));
      end else if (pick < 62) begin
        pending_reqs.push_back(make_req(KIND_DOWN, val, nm, ky, tid, $urandom));
      end else if (pick < 86) begin
        pending_reqs.push_back(make_req(KIND_UP, val, nm, ky, tid, $urandom));
      end else if (pick < 97) begin
        pending_reqs.push_back(make_req(KIND_CLOSE, val, nm, ky, tid, $urandom));
      end else begin
        pending_reqs.push_back(make_req(3'($urandom_range(7, 5)), val, nm, ky, tid,
                                        $urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("semaphore_table_with_wait_queues regression: pass");
    end else begin
      $display("semaphore_table_with_wait_queues regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/semtab_pkg.sv
rtl/core/semaphore_table_with_wait_queues.sv
tb/testbench.sv
